FILE: rtl/core/mbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Shared widths, register indexes and the types that pass between modules.
// ----------------------------------------------------------------------------
package mbe_pkg;

  localparam int FRAC_BITS  = 28;
  localparam int DATA_W     = 32;
  localparam int PROD_W     = 64;
  localparam int COUNT_W    = 16;
  localparam int INDEX_W    = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int STEP_PROD_W = DATA_W + INDEX_W + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_REAL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_IMAG     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_REAL       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_IMAG       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_LIMIT = 3'd4;

  localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'd4096;

  localparam logic signed [PROD_W-1:0] NORM_LIMIT = 64'sd4 <<< FRAC_BITS;

  typedef struct packed {
    logic signed [DATA_W-1:0] origin_real;
    logic signed [DATA_W-1:0] origin_imag;
    logic signed [DATA_W-1:0] step_real;
    logic signed [DATA_W-1:0] step_imag;
    logic [COUNT_W-1:0]       iteration_limit;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic c_add;
    logic square;
    logic update;
    logic result_load;
  } cmd_t;

  typedef struct packed {
    logic finished;
  } status_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'(32'sh7FFF_FFFF);
    lo = PROD_W'(32'sh8000_0000);
    if (x > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (x < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = x[DATA_W-1:0];
    end
  endfunction

endpackage

FILE: rtl/core/mbe_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time configuration registers
// Write-only register file for the view origin, step and iteration limit.
// ----------------------------------------------------------------------------
module mbe_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [mbe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mbe_pkg::DATA_W-1:0]    cfg_data,
  output mbe_pkg::cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_real     <= '0;
      cfg.origin_imag     <= '0;
      cfg.step_real       <= '0;
      cfg.step_imag       <= '0;
      cfg.iteration_limit <= mbe_pkg::LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        mbe_pkg::CFG_ORIGIN_REAL:     cfg.origin_real     <= cfg_data;
        mbe_pkg::CFG_ORIGIN_IMAG:     cfg.origin_imag     <= cfg_data;
        mbe_pkg::CFG_STEP_REAL:       cfg.step_real       <= cfg_data;
        mbe_pkg::CFG_STEP_IMAG:       cfg.step_imag       <= cfg_data;
        mbe_pkg::CFG_ITERATION_LIMIT: cfg.iteration_limit <= cfg_data[mbe_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/mbe_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time datapath
// Forms the point c, then squares z and updates it on each iteration.
// ----------------------------------------------------------------------------
module mbe_datapath (
  input  logic                        clk,
  input  mbe_pkg::cfg_t               cfg,
  input  logic [mbe_pkg::INDEX_W-1:0] column,
  input  logic [mbe_pkg::INDEX_W-1:0] row,
  input  mbe_pkg::cmd_t               cmd,
  output mbe_pkg::status_t            status,
  output logic [mbe_pkg::COUNT_W-1:0] iterations
);

  logic signed [mbe_pkg::STEP_PROD_W-1:0] prod_cr;
  logic signed [mbe_pkg::STEP_PROD_W-1:0] prod_ci;
  logic signed [mbe_pkg::DATA_W-1:0]      c_real;
  logic signed [mbe_pkg::DATA_W-1:0]      c_imag;
  logic signed [mbe_pkg::DATA_W-1:0]      z_real;
  logic signed [mbe_pkg::DATA_W-1:0]      z_imag;
  logic signed [mbe_pkg::PROD_W-1:0]      prod_rr;
  logic signed [mbe_pkg::PROD_W-1:0]      prod_ii;
  logic signed [mbe_pkg::PROD_W-1:0]      prod_ri;
  logic [mbe_pkg::COUNT_W-1:0]            step_count;

  logic signed [mbe_pkg::PROD_W-1:0] rr;
  logic signed [mbe_pkg::PROD_W-1:0] ii;
  logic signed [mbe_pkg::PROD_W-1:0] ri2;
  logic signed [mbe_pkg::PROD_W-1:0] norm;
  logic signed [mbe_pkg::PROD_W-1:0] real_sum;
  logic signed [mbe_pkg::PROD_W-1:0] imag_sum;

  // Arithmetic shifts of the products round towards minus infinity.
  assign rr       = prod_rr >>> mbe_pkg::FRAC_BITS;
  assign ii       = prod_ii >>> mbe_pkg::FRAC_BITS;
  assign ri2      = prod_ri >>> (mbe_pkg::FRAC_BITS - 1);
  assign norm     = rr + ii;
  assign real_sum = rr - ii + mbe_pkg::PROD_W'(c_real);
  assign imag_sum = ri2 + mbe_pkg::PROD_W'(c_imag);

  assign status.finished = (step_count == cfg.iteration_limit) || (norm >= mbe_pkg::NORM_LIMIT);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prod_cr <= cfg.step_real * $signed({1'b0, column});
      prod_ci <= cfg.step_imag * $signed({1'b0, row});
    end
    if (cmd.c_add) begin
      c_real     <= mbe_pkg::sat32(mbe_pkg::PROD_W'(cfg.origin_real)
                                   + mbe_pkg::PROD_W'(prod_cr));
      c_imag     <= mbe_pkg::sat32(mbe_pkg::PROD_W'(cfg.origin_imag)
                                   + mbe_pkg::PROD_W'(prod_ci));
      z_real     <= '0;
      z_imag     <= '0;
      step_count <= '0;
    end
    if (cmd.square) begin
      prod_rr <= z_real * z_real;
      prod_ii <= z_imag * z_imag;
      prod_ri <= z_real * z_imag;
    end
    if (cmd.update) begin
      z_real     <= mbe_pkg::sat32(real_sum);
      z_imag     <= mbe_pkg::sat32(imag_sum);
      step_count <= step_count + 1'b1;
    end
    if (cmd.result_load) begin
      iterations <= (step_count == cfg.iteration_limit) ? '0 : step_count;
    end
  end

endmodule

FILE: rtl/core/mbe_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time controller
// Sequences one pixel at a time and owns both channel handshakes.
// ----------------------------------------------------------------------------
module mbe_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  mbe_pkg::status_t  status,
  output mbe_pkg::cmd_t     cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CADD = 3'd1;
  localparam logic [2:0] ST_SQ   = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_HOLD = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;
  logic       slot_free;

  assign in_stall  = (state != ST_IDLE);
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CADD;
        end
      end
      ST_CADD: begin
        cmd.c_add  = 1'b1;
        state_next = ST_SQ;
      end
      ST_SQ: begin
        cmd.square = 1'b1;
        state_next = ST_CHK;
      end
      ST_CHK: begin
        if (!status.finished) begin
          cmd.update = 1'b1;
          state_next = ST_SQ;
        end else if (slot_free) begin
          cmd.result_load = 1'b1;
          state_next      = ST_IDLE;
        end else begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          cmd.result_load = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.result_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: rtl/core/mandelbrot_escape_time.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel engine
// Computes the escape count of one pixel in Q4.28 fixed point.
// ----------------------------------------------------------------------------
// The input channel carries a pixel column and row; a transaction completes
// when in_valid is high and in_stall is low. The output channel returns one
// iteration count per pixel, zero when the iteration limit is reached.
// The configuration port writes the origin, step and limit registers, one
// per cycle while cfg_write is high; they must only change between pixels.
// One pixel is worked on at a time. The point c is formed by multiplying the
// steps by column and row and then adding and saturating the origin, and each
// iteration of z = z*z + c passes through the three 32 x 32 squaring
// multipliers and then the add, saturate and escape test. The engine returns
// to idle as the result is loaded, ready for the next pixel.
// The result sits in an output register, so a stalled receiver does not stop
// the next pixel from being accepted and computed; only when a second result
// is ready while the first still waits does the engine hold.
// Synchronous reset returns the engine to idle with no result pending and
// restores the register defaults (limit 4096, everything else zero).
// ----------------------------------------------------------------------------
module mandelbrot_escape_time (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mbe_pkg::INDEX_W-1:0]    column,
  input  logic [mbe_pkg::INDEX_W-1:0]    row,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mbe_pkg::COUNT_W-1:0]    iterations,
  input  logic                           cfg_write,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbe_pkg::DATA_W-1:0]     cfg_data
);

  mbe_pkg::cfg_t    cfg;
  mbe_pkg::cmd_t    cmd;
  mbe_pkg::status_t status;

  mbe_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mbe_controller u_controller (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mbe_datapath u_datapath (
    .clk        (clk),
    .cfg        (cfg),
    .column     (column),
    .row        (row),
    .cmd        (cmd),
    .status     (status),
    .iterations (iterations)
  );

endmodule

FILE: rtl/core/mbe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time port checker
// Checks the timing that the engine shows on its ports.
// ----------------------------------------------------------------------------
module mbe_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [mbe_pkg::COUNT_W-1:0] iterations
);

  // A pixel keeps the input stalled through the c-add, square and check states after its transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall ##1 in_stall ##1 in_stall)
    else $error("input taken again too soon after a transaction");

  a_reset_clean: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("engine not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(iterations)))
    else $error("stalled result changed or dropped");

  // A result cannot appear without a preceding busy cycle.
  a_result_needs_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a pixel in progress");

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .iterations (iterations)
);
